[sv/assert_macros.svh]
// Assertion macros used by the top level of the reassembly buffer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check that an expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[sv/iorb_pkg.sv]
// Types, codes and constants shared by the reassembly buffer modules
`default_nettype none

package iorb_pkg;

   localparam int SEQ_W = 31;
   localparam int LEN_W = 11;
   localparam int TAG_W = 8;

   localparam int DEFAULT_BUFFER_SLOTS = 16;
   localparam int DEFAULT_MAX_PAYLOAD  = 1456;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_END   = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic [SEQ_W-1:0] packet_seq;
      logic [LEN_W-1:0] packet_length;
      logic [TAG_W-1:0] payload_tag;
   } req_payload_type;

   typedef struct packed {
      result_kind_type  result_kind;
      logic [SEQ_W-1:0] write_offset;
      logic [LEN_W-1:0] write_length;
      logic [TAG_W-1:0] write_tag;
      logic [SEQ_W-1:0] ack_number;
      logic             dropped;
      logic             last_of_run;
   } rsp_payload_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture the accepted transaction
      logic decide;   // classify it and emit its first result
      logic drain;    // emit one drained slot or the closing ack
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic done;      // end of transfer seen
      logic out_free;  // result register can take a new result
      logic in_order;  // captured packet starts at the expected byte
      logic drain_hit; // a buffered slot starts at the expected byte
   } dp_status_type;

endpackage

`default_nettype wire

[sv/iorb_ctrl.sv]
// Controller state machine of the reassembly buffer
`default_nettype none

module iorb_ctrl
   import iorb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Sequence one transaction: accept, classify, then drain
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // drop everything once the transfer has ended
               if (!status.done) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               cmd.decide = 1'b1;
               state_in   = status.in_order ? ST_DRAIN : ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.drain = 1'b1;
               if (!status.drain_hit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[sv/iorb_datapath.sv]
// Datapath of the reassembly buffer: slots, expected byte number, result register
`default_nettype none

module iorb_datapath
   import iorb_pkg::*;
#(
   parameter int BUFFER_SLOTS = DEFAULT_BUFFER_SLOTS,
   parameter int MAX_PAYLOAD  = DEFAULT_MAX_PAYLOAD
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dp_cmd_type      cmd,
   output dp_status_type        status,
   input  wire req_payload_type req_data,
   input  wire logic            csr_wr_en,
   input  wire logic [SEQ_W-1:0] csr_wr_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_data
);

   localparam int SLOT_IDX_W = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;

   // Captured transaction
   logic [SEQ_W-1:0] cur_seq_ff;
   logic [LEN_W-1:0] cur_len_ff;
   logic [TAG_W-1:0] cur_tag_ff;

   // Reorder slots
   logic [BUFFER_SLOTS-1:0] slot_valid_ff;
   logic [BUFFER_SLOTS-1:0] slot_valid_in;
   logic [SEQ_W-1:0]        slot_seq_ff [BUFFER_SLOTS];
   logic [LEN_W-1:0]        slot_len_ff [BUFFER_SLOTS];
   logic [TAG_W-1:0]        slot_tag_ff [BUFFER_SLOTS];

   logic [SEQ_W-1:0] next_expected_ff;
   logic [SEQ_W-1:0] next_expected_in;
   logic             transfer_done_ff;
   logic             transfer_done_in;

   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;
   logic            rsp_load;

   logic                  hit_found;
   logic [SLOT_IDX_W-1:0] hit_idx;
   logic [SLOT_IDX_W-1:0] free_idx;
   logic [BUFFER_SLOTS-1:0] free_vec;
   logic                  two_free;
   logic                  dup;
   logic [SEQ_W-1:0]      hit_end;
   logic [SEQ_W-1:0]      cur_end;
   logic                  is_end;
   logic                  is_bad;
   logic                  is_ahead;
   logic                  is_in_order;
   logic                  do_insert;

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_seq_ff <= req_data.packet_seq;
         cur_len_ff <= req_data.packet_length;
         cur_tag_ff <= req_data.payload_tag;
      end
   end

   // Search the slots: first match on the expected byte, first free slot, duplicates
   always_comb begin
      hit_found = 1'b0;
      hit_idx   = '0;
      free_idx  = '0;
      dup       = 1'b0;
      for (int i = BUFFER_SLOTS - 1; i >= 0; i--) begin
         if (slot_valid_ff[i] && slot_seq_ff[i] == next_expected_ff) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_IDX_W'(i);
         end
         if (!slot_valid_ff[i]) begin
            free_idx = SLOT_IDX_W'(i);
         end
         if (slot_valid_ff[i] && slot_seq_ff[i] == cur_seq_ff) begin
            dup = 1'b1;
         end
      end
   end

   // Room for an ahead packet needs two free slots: one stays reserved
   assign free_vec = ~slot_valid_ff;
   assign two_free = |(free_vec & (free_vec - 1'b1));

   assign hit_end = slot_seq_ff[hit_idx] + SEQ_W'(slot_len_ff[hit_idx]);
   assign cur_end = cur_seq_ff + SEQ_W'(cur_len_ff);

   // Classify the captured packet
   assign is_end      = (cur_len_ff == '0);
   assign is_bad      = (cur_len_ff > LEN_W'(MAX_PAYLOAD)) || (cur_seq_ff < next_expected_ff);
   assign is_ahead    = (cur_seq_ff > next_expected_ff);
   assign is_in_order = !is_end && !is_bad && !is_ahead;
   assign do_insert   = cmd.decide && !is_end && !is_bad && is_ahead && !dup && two_free;

   // Build the next result
   always_comb begin
      rsp_data_in             = '0;
      rsp_data_in.result_kind = KIND_ACK;
      rsp_data_in.ack_number  = next_expected_ff;
      rsp_data_in.last_of_run = 1'b1;
      if (cmd.decide) begin
         if (is_end) begin
            rsp_data_in.result_kind = KIND_END;
         end else if (is_bad) begin
            rsp_data_in.dropped = 1'b1;
         end else if (is_ahead) begin
            rsp_data_in.dropped = dup || !two_free;
         end else begin
            rsp_data_in.result_kind  = KIND_WRITE;
            rsp_data_in.write_offset = cur_seq_ff;
            rsp_data_in.write_length = cur_len_ff;
            rsp_data_in.write_tag    = cur_tag_ff;
            rsp_data_in.ack_number   = cur_end;
            rsp_data_in.last_of_run  = 1'b0;
         end
      end else if (hit_found) begin
         rsp_data_in.result_kind  = KIND_WRITE;
         rsp_data_in.write_offset = slot_seq_ff[hit_idx];
         rsp_data_in.write_length = slot_len_ff[hit_idx];
         rsp_data_in.write_tag    = slot_tag_ff[hit_idx];
         rsp_data_in.ack_number   = hit_end;
         rsp_data_in.last_of_run  = 1'b0;
      end
   end

   assign rsp_load = cmd.decide || cmd.drain;

   // Load or advance the expected byte number and the end flag
   always_comb begin
      next_expected_in = next_expected_ff;
      transfer_done_in = transfer_done_ff;
      if (csr_wr_en) begin
         next_expected_in = csr_wr_data;
         transfer_done_in = 1'b0;
      end else if (cmd.decide) begin
         if (is_end) begin
            transfer_done_in = 1'b1;
         end else if (is_in_order) begin
            next_expected_in = cur_end;
         end
      end else if (cmd.drain && hit_found) begin
         next_expected_in = hit_end;
      end
   end

   // Update slot valid bits: clear on a CSR write, insert, drain, or drop overtaken slots
   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (csr_wr_en) begin
         slot_valid_in = '0;
      end else if (do_insert) begin
         slot_valid_in[free_idx] = 1'b1;
      end else if (cmd.drain) begin
         if (hit_found) begin
            slot_valid_in[hit_idx] = 1'b0;
         end else begin
            for (int i = 0; i < BUFFER_SLOTS; i++) begin
               if (slot_seq_ff[i] < next_expected_ff) begin
                  slot_valid_in[i] = 1'b0;
               end
            end
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff    <= '0;
         next_expected_ff <= '0;
         transfer_done_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         slot_valid_ff    <= slot_valid_in;
         next_expected_ff <= next_expected_in;
         transfer_done_ff <= transfer_done_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Write slot contents and the result register
   always_ff @(posedge clock) begin
      if (do_insert) begin
         slot_seq_ff[free_idx] <= cur_seq_ff;
         slot_len_ff[free_idx] <= cur_len_ff;
         slot_tag_ff[free_idx] <= cur_tag_ff;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.done      = transfer_done_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.in_order  = is_in_order;
   assign status.drain_hit = hit_found;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[sv/in_order_reassembly_buffer.sv]
// Top level of the in-order reassembly buffer
`default_nettype none

`include "assert_macros.svh"

// Receive-side reassembly of a byte-sequenced transfer. Each req_ transaction is a
// packet descriptor; packets ahead of the expected byte wait in BUFFER_SLOTS slots
// (one of them is always kept free as a reserve), stale, oversize, duplicate or
// overflowing packets are dropped, and an in-order packet is written out followed
// by every buffered packet that now continues without a gap. Each packet closes
// with a cumulative ack; a zero-length packet yields an end result, after which
// packets are taken and ignored until csr_wr_en loads a new initial expected byte
// number and clears the slots. A packet is accepted, then classified with its first
// result; an in-order packet then drains its continuing slots one result at a time
// and closes with the ack. Each result waits in the result register until taken by
// rsp_ready, stalling the next; a new packet is accepted only after the last result.
module in_order_reassembly_buffer
   import iorb_pkg::*;
#(
   parameter int BUFFER_SLOTS = DEFAULT_BUFFER_SLOTS,
   parameter int MAX_PAYLOAD  = DEFAULT_MAX_PAYLOAD
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_payload_type  req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_payload_type       rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [SEQ_W-1:0] csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   iorb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   iorb_datapath #(
      .BUFFER_SLOTS (BUFFER_SLOTS),
      .MAX_PAYLOAD  (MAX_PAYLOAD)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // A result is never produced over one still waiting to be taken
   `ASSERT_ALWAYS(a_no_overwrite, clock, reset, !(cmd.decide || cmd.drain) || status.out_free, "result register overwritten")

   // No new transaction is taken while one is still being worked on
   `ASSERT_ALWAYS(a_ready_only_idle, clock, reset, !(req_ready && (cmd.decide || cmd.drain)), "accept during work")

   // A packet that is not in order finishes with its classification
   `ASSERT_NEXT(a_return_idle, clock, reset, cmd.decide && !status.in_order, req_ready, "no return to idle")

endmodule

`default_nettype wire
